// ===== hdl/lfps_pkg.sv =====
// Shared constants, register codes and control types for the line follower PID steering block.
`timescale 1ns / 1ps
`default_nettype none

package lfps_pkg;

    localparam int NUM_SENSORS = 13;
    localparam int SAMPLE_W    = 10;
    localparam int POS_W       = 4;
    localparam int FRAC_BITS   = 8;
    localparam int SUM_W       = 7;
    localparam int CNT_W       = 4;
    localparam int LINE_W      = 12;
    localparam int ERR_W       = 13;
    localparam int DIFF_W      = 14;
    localparam int INTEG_W     = 24;
    localparam int GAIN_W      = 10;
    localparam int DRIVE_W     = 10;
    localparam int CORR_W      = 16;
    localparam int QUO_W       = SUM_W + FRAC_BITS;
    localparam int DIVCNT_W    = 4;
    localparam int MUL_A_W     = GAIN_W + 1;
    localparam int PROD_W      = MUL_A_W + INTEG_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int SHIFT_W     = ACC_W - FRAC_BITS;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = POS_W;
    localparam int M_TDATA_W   = 56;

    localparam logic [POS_W-1:0]    LAST_POS     = POS_W'(NUM_SENSORS - 1);
    localparam logic [SUM_W-1:0]    SUM_MAX      = '1;
    localparam logic [CNT_W-1:0]    CNT_MAX      = '1;
    localparam logic [CNT_W-1:0]    CNT_ALL      = CNT_W'(NUM_SENSORS);
    localparam logic [LINE_W-1:0]   POS_MAX      = LINE_W'((NUM_SENSORS - 1) << FRAC_BITS);
    localparam logic [LINE_W-1:0]   PREV_POS_RST = LINE_W'(6 << FRAC_BITS);
    localparam logic [DRIVE_W-1:0]  DRIVE_MAX    = '1;

    localparam logic [SAMPLE_W-1:0] THRESH_RST   = SAMPLE_W'(700);
    localparam logic [LINE_W-1:0]   CENTRE_RST   = LINE_W'(1664);
    localparam logic [DRIVE_W-1:0]  BASE_RST     = DRIVE_W'(300);
    localparam logic [GAIN_W-1:0]   GAIN_P_RST   = GAIN_W'(12);
    localparam logic [GAIN_W-1:0]   GAIN_D_RST   = GAIN_W'(300);
    localparam logic [GAIN_W-1:0]   GAIN_I_RST   = GAIN_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_CENTRE    = 3'd1,
        CFG_BASE      = 3'd2,
        CFG_GAIN_P    = 3'd3,
        CFG_GAIN_D    = 3'd4,
        CFG_GAIN_I    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] threshold;
        logic [LINE_W-1:0]   centre;
        logic [DRIVE_W-1:0]  base;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_d;
        logic [GAIN_W-1:0]   gain_i;
    } t_cfg;

    typedef struct packed {
        logic accum;
        logic load;
        logic div_step;
        logic calc_err;
        logic pid_int;
        logic pid_gd;
        logic pid_gi;
        logic pid_sum;
        logic corr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_pos;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/line_follow_pid_steer.sv =====
// Top level: line position from white-sensor centroid, PID steering of two motor duties.
// Non-final samples are accepted one per cycle while the sequencer is idle. The frame-closing
// sample is followed by a busy sequence (load, divider steps, then error, integral, gain
// products, sum, correction and output load) before the result is registered and output valid
// rises, one frame at a time. The divider produces one quotient bit per cycle.
// Synchronous active-low reset restores defaults, clears PID state, drops valid, holds ready low.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pid_steer (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [lfps_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // [9:0] sample_value
    input  wire  [lfps_pkg::S_TUSER_W-1:0]     s_axis_tuser,   // [3:0] sensor_position
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [9:0] left_drive, [19:10] right_drive, [20] stop_motors,
    // [32:21] line_position, [48:33] correction, [55:49] zero
    output logic [lfps_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [lfps_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire  [lfps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PAD_W = lfps_pkg::M_TDATA_W - 2 * lfps_pkg::DRIVE_W - 1
                           - lfps_pkg::LINE_W - lfps_pkg::CORR_W;

    lfps_pkg::t_cfg     w_cfg;
    lfps_pkg::t_cmd     w_cmd;
    lfps_pkg::t_status  w_status;

    logic [lfps_pkg::DRIVE_W-1:0]       w_left;
    logic [lfps_pkg::DRIVE_W-1:0]       w_right;
    logic                               w_stop;
    logic [lfps_pkg::LINE_W-1:0]        w_line;
    logic signed [lfps_pkg::CORR_W-1:0] w_corr;

    lfps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lfps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lfps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_sample    (s_axis_tdata[lfps_pkg::SAMPLE_W-1:0]),
        .i_pos       (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_left      (w_left),
        .o_right     (w_right),
        .o_stop      (w_stop),
        .o_line      (w_line),
        .o_corr      (w_corr)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, w_corr, w_line, w_stop, w_right, w_left};

endmodule

`default_nettype wire

// ===== hdl/lfps_cfg.sv =====
// Configuration register file written through the index/data write channel.
`timescale 1ns / 1ps
`default_nettype none

module lfps_cfg (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [lfps_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire  [lfps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output lfps_pkg::t_cfg                    o_cfg
);

    lfps_pkg::t_cfg r_cfg;
    logic           r_cfg_ready;

    assign o_cfg_ready = r_cfg_ready;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready <= 1'b0;
        end else begin
            r_cfg_ready <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= lfps_pkg::THRESH_RST;
            r_cfg.centre    <= lfps_pkg::CENTRE_RST;
            r_cfg.base      <= lfps_pkg::BASE_RST;
            r_cfg.gain_p    <= lfps_pkg::GAIN_P_RST;
            r_cfg.gain_d    <= lfps_pkg::GAIN_D_RST;
            r_cfg.gain_i    <= lfps_pkg::GAIN_I_RST;
        end else if (i_cfg_valid && r_cfg_ready) begin
            case (lfps_pkg::t_cfg_idx'(i_cfg_addr))
                lfps_pkg::CFG_THRESHOLD: begin
                    r_cfg.threshold <= i_cfg_data[lfps_pkg::SAMPLE_W-1:0];
                end
                lfps_pkg::CFG_CENTRE: begin
                    r_cfg.centre <= i_cfg_data[lfps_pkg::LINE_W-1:0];
                end
                lfps_pkg::CFG_BASE: begin
                    r_cfg.base <= i_cfg_data[lfps_pkg::DRIVE_W-1:0];
                end
                lfps_pkg::CFG_GAIN_P: begin
                    r_cfg.gain_p <= i_cfg_data[lfps_pkg::GAIN_W-1:0];
                end
                lfps_pkg::CFG_GAIN_D: begin
                    r_cfg.gain_d <= i_cfg_data[lfps_pkg::GAIN_W-1:0];
                end
                lfps_pkg::CFG_GAIN_I: begin
                    r_cfg.gain_i <= i_cfg_data[lfps_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lfps_ctrl.sv =====
// Sequencer for accumulation, centroid division, PID products and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module lfps_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  lfps_pkg::t_status  i_status,
    output lfps_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_ERR,
        S_INT,
        S_GD,
        S_GI,
        S_SUM,
        S_COR,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   w_accept;

    assign w_accept   = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_status.last_pos) n_state = S_LOAD;
            end
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) n_state = S_ERR;
            end
            S_ERR:  n_state = S_INT;
            S_INT:  n_state = S_GD;
            S_GD:   n_state = S_GI;
            S_GI:   n_state = S_SUM;
            S_SUM:  n_state = S_COR;
            S_COR:  n_state = S_OUT;
            S_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.accum    = w_accept;
        o_cmd.load     = (r_state == S_LOAD);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.calc_err = (r_state == S_ERR);
        o_cmd.pid_int  = (r_state == S_INT);
        o_cmd.pid_gd   = (r_state == S_GD);
        o_cmd.pid_gi   = (r_state == S_GI);
        o_cmd.pid_sum  = (r_state == S_SUM);
        o_cmd.corr     = (r_state == S_COR);
        o_cmd.out_load = (r_state == S_OUT) && i_status.out_free;
    end

endmodule

`default_nettype wire

// ===== hdl/lfps_dp.sv =====
// Datapath: white-sensor accumulation, bit-serial centroid divider, shared PID multiplier.
`timescale 1ns / 1ps
`default_nettype none

module lfps_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  lfps_pkg::t_cfg                      i_cfg,
    input  lfps_pkg::t_cmd                      i_cmd,
    output lfps_pkg::t_status                   o_status,
    input  wire  [lfps_pkg::SAMPLE_W-1:0]       i_sample,
    input  wire  [lfps_pkg::POS_W-1:0]          i_pos,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [lfps_pkg::DRIVE_W-1:0]        o_left,
    output logic [lfps_pkg::DRIVE_W-1:0]        o_right,
    output logic                                o_stop,
    output logic [lfps_pkg::LINE_W-1:0]         o_line,
    output logic signed [lfps_pkg::CORR_W-1:0]  o_corr
);

    localparam int DRV_SUM_W = lfps_pkg::CORR_W + 2;

    // frame accumulation
    logic [lfps_pkg::SUM_W-1:0]   r_sum;
    logic [lfps_pkg::CNT_W-1:0]   r_count;
    logic [lfps_pkg::SUM_W:0]     w_sum_ext;
    logic                         w_hit;

    // divider
    logic [lfps_pkg::QUO_W-1:0]    r_div_q;
    logic [lfps_pkg::CNT_W-1:0]    r_div_rem;
    logic [lfps_pkg::CNT_W-1:0]    r_divisor;
    logic [lfps_pkg::DIVCNT_W-1:0] r_div_cnt;
    logic                          r_cnt_zero;
    logic                          r_stop;
    logic [lfps_pkg::CNT_W:0]      w_rem_sh;
    logic                          w_ge;

    // PID
    logic [lfps_pkg::LINE_W-1:0]         r_prev_pos;
    logic [lfps_pkg::LINE_W-1:0]         r_line;
    logic [lfps_pkg::LINE_W-1:0]         w_line;
    logic signed [lfps_pkg::ERR_W-1:0]   r_err;
    logic signed [lfps_pkg::ERR_W-1:0]   r_prev_err;
    logic signed [lfps_pkg::DIFF_W-1:0]  r_diff;
    logic signed [lfps_pkg::INTEG_W-1:0] r_integ;
    logic signed [lfps_pkg::INTEG_W:0]   w_integ_sum;
    logic signed [lfps_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [lfps_pkg::INTEG_W-1:0] w_mul_b;
    logic signed [lfps_pkg::PROD_W-1:0]  w_prod;
    logic signed [lfps_pkg::PROD_W-1:0]  r_prod;
    logic signed [lfps_pkg::ACC_W-1:0]   r_acc;
    logic signed [lfps_pkg::ACC_W-1:0]   w_bias;
    logic signed [lfps_pkg::ACC_W-1:0]   w_round;
    logic [lfps_pkg::SHIFT_W-1:0]        w_shift;
    logic signed [lfps_pkg::CORR_W-1:0]  r_corr;
    logic signed [lfps_pkg::CORR_W-1:0]  w_corr;
    logic signed [DRV_SUM_W-1:0]         w_base_s;
    logic signed [DRV_SUM_W-1:0]         w_left_s;
    logic signed [DRV_SUM_W-1:0]         w_right_s;
    logic [lfps_pkg::DRIVE_W-1:0]        w_left;
    logic [lfps_pkg::DRIVE_W-1:0]        w_right;

    // output register
    logic                                r_out_valid;
    logic [lfps_pkg::DRIVE_W-1:0]        r_o_left;
    logic [lfps_pkg::DRIVE_W-1:0]        r_o_right;
    logic                                r_o_stop;
    logic [lfps_pkg::LINE_W-1:0]         r_o_line;
    logic signed [lfps_pkg::CORR_W-1:0]  r_o_corr;

    assign o_status.last_pos = (i_pos == lfps_pkg::LAST_POS);
    assign o_status.div_last = (r_div_cnt == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign w_hit     = (i_pos <= lfps_pkg::LAST_POS) && (i_sample <= i_cfg.threshold);
    assign w_sum_ext = {1'b0, r_sum} + (lfps_pkg::SUM_W + 1)'(i_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.accum && w_hit) begin
            r_sum   <= w_sum_ext[lfps_pkg::SUM_W] ? lfps_pkg::SUM_MAX
                                                  : w_sum_ext[lfps_pkg::SUM_W-1:0];
            if (r_count != lfps_pkg::CNT_MAX) r_count <= r_count + 1'b1;
        end
    end

    // restoring division, one quotient bit per cycle
    assign w_rem_sh = {r_div_rem, r_div_q[lfps_pkg::QUO_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div_q    <= {r_sum, {lfps_pkg::FRAC_BITS{1'b0}}};
            r_div_rem  <= '0;
            r_divisor  <= r_count;
            r_div_cnt  <= lfps_pkg::DIVCNT_W'(lfps_pkg::QUO_W - 1);
            r_cnt_zero <= (r_count == '0);
            r_stop     <= (r_count >= lfps_pkg::CNT_ALL);
        end else if (i_cmd.div_step) begin
            r_div_rem <= w_ge ? lfps_pkg::CNT_W'(w_rem_sh - {1'b0, r_divisor})
                              : w_rem_sh[lfps_pkg::CNT_W-1:0];
            r_div_q   <= {r_div_q[lfps_pkg::QUO_W-2:0], w_ge};
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_comb begin
        if (r_cnt_zero) begin
            w_line = r_prev_pos;
        end else if (r_div_q > lfps_pkg::QUO_W'(lfps_pkg::POS_MAX)) begin
            w_line = lfps_pkg::POS_MAX;
        end else begin
            w_line = r_div_q[lfps_pkg::LINE_W-1:0];
        end
    end

    assign w_integ_sum = (lfps_pkg::INTEG_W + 1)'(r_integ) + (lfps_pkg::INTEG_W + 1)'(r_err);

    // shared multiplier operand select
    always_comb begin
        if (i_cmd.pid_gd) begin
            w_mul_a = $signed({1'b0, i_cfg.gain_d});
            w_mul_b = lfps_pkg::INTEG_W'(r_diff);
        end else if (i_cmd.pid_gi) begin
            w_mul_a = $signed({1'b0, i_cfg.gain_i});
            w_mul_b = r_integ;
        end else begin
            w_mul_a = $signed({1'b0, i_cfg.gain_p});
            w_mul_b = lfps_pkg::INTEG_W'(r_err);
        end
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pos <= lfps_pkg::PREV_POS_RST;
            r_prev_err <= '0;
            r_integ    <= '0;
        end else begin
            if (i_cmd.calc_err) r_prev_pos <= w_line;
            if (i_cmd.pid_sum) r_prev_err <= r_err;
            if (i_cmd.pid_int) begin
                if (w_integ_sum[lfps_pkg::INTEG_W] != w_integ_sum[lfps_pkg::INTEG_W-1]) begin
                    r_integ <= {w_integ_sum[lfps_pkg::INTEG_W],
                                {(lfps_pkg::INTEG_W-1){~w_integ_sum[lfps_pkg::INTEG_W]}}};
                end else begin
                    r_integ <= w_integ_sum[lfps_pkg::INTEG_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_err) begin
            r_line <= w_line;
            r_err  <= $signed({1'b0, w_line}) - $signed({1'b0, i_cfg.centre});
        end
        if (i_cmd.pid_int) begin
            r_diff <= lfps_pkg::DIFF_W'(r_err) - lfps_pkg::DIFF_W'(r_prev_err);
            r_prod <= w_prod;
        end
        if (i_cmd.pid_gd) begin
            r_acc  <= lfps_pkg::ACC_W'(r_prod);
            r_prod <= w_prod;
        end
        if (i_cmd.pid_gi) begin
            r_acc  <= r_acc + lfps_pkg::ACC_W'(r_prod);
            r_prod <= w_prod;
        end
        if (i_cmd.pid_sum) r_acc <= r_acc + lfps_pkg::ACC_W'(r_prod);
        if (i_cmd.corr) r_corr <= w_corr;
    end

    // divide by 2^FRAC_BITS truncating toward zero, then saturate
    assign w_bias  = r_acc[lfps_pkg::ACC_W-1] ?
                     lfps_pkg::ACC_W'((1 << lfps_pkg::FRAC_BITS) - 1) : '0;
    assign w_round = r_acc + w_bias;
    assign w_shift = w_round[lfps_pkg::ACC_W-1:lfps_pkg::FRAC_BITS];

    always_comb begin
        if (!w_shift[lfps_pkg::SHIFT_W-1] &&
            (|w_shift[lfps_pkg::SHIFT_W-2:lfps_pkg::CORR_W-1])) begin
            w_corr = {1'b0, {(lfps_pkg::CORR_W-1){1'b1}}};
        end else if (w_shift[lfps_pkg::SHIFT_W-1] &&
                     !(&w_shift[lfps_pkg::SHIFT_W-2:lfps_pkg::CORR_W-1])) begin
            w_corr = {1'b1, {(lfps_pkg::CORR_W-1){1'b0}}};
        end else begin
            w_corr = w_shift[lfps_pkg::CORR_W-1:0];
        end
    end

    assign w_base_s  = $signed({{(DRV_SUM_W - lfps_pkg::DRIVE_W){1'b0}}, i_cfg.base});
    assign w_left_s  = w_base_s - DRV_SUM_W'(r_corr);
    assign w_right_s = w_base_s + DRV_SUM_W'(r_corr);

    always_comb begin
        if (w_left_s[DRV_SUM_W-1]) begin
            w_left = '0;
        end else if (|w_left_s[DRV_SUM_W-2:lfps_pkg::DRIVE_W]) begin
            w_left = lfps_pkg::DRIVE_MAX;
        end else begin
            w_left = w_left_s[lfps_pkg::DRIVE_W-1:0];
        end
        if (w_right_s[DRV_SUM_W-1]) begin
            w_right = '0;
        end else if (|w_right_s[DRV_SUM_W-2:lfps_pkg::DRIVE_W]) begin
            w_right = lfps_pkg::DRIVE_MAX;
        end else begin
            w_right = w_right_s[lfps_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_left  <= w_left;
            r_o_right <= w_right;
            r_o_stop  <= r_stop;
            r_o_line  <= r_line;
            r_o_corr  <= r_corr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left      = r_o_left;
    assign o_right     = r_o_right;
    assign o_stop      = r_o_stop;
    assign o_line      = r_o_line;
    assign o_corr      = r_o_corr;

endmodule

`default_nettype wire
